### design/sslr_pkg.sv
// ----------------------------------------------------------------------------
// sslr_pkg
// Shared types, constants and microcode table of the speed slew-rate limiter.
// ----------------------------------------------------------------------------
package sslr_pkg;

   localparam int SPEED_W   = 32;
   localparam int DT_W      = 16;
   localparam int FRAC_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int PC_W      = 3;
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int REQ_W     = DT_W + 2 * SPEED_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACC      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACC_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_SPD_THR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DEC      = 3'd4;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_PREP,
      OP_MUL_INTERP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_ACC_FORM,
      OP_MUL_STEP,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_SKIP,
      COND_DIV_MORE
   } cond_type;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [PC_W-1:0]  jump;
      logic             last;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   load;
   } ctl_type;

   typedef struct packed {
      logic skip;
      logic div_more;
   } flags_type;

   localparam logic [PC_W-1:0] PC_ACC_FORM = 3'd5;
   localparam logic [PC_W-1:0] PC_DIV_STEP = 3'd4;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_NONE, jump: '0, last: 1'b0};
      unique case (pc)
         3'd0: w = '{op: OP_PREP,       cond: COND_NONE,     jump: '0,          last: 1'b0};
         3'd1: w = '{op: OP_NOP,        cond: COND_SKIP,     jump: PC_ACC_FORM, last: 1'b0};
         3'd2: w = '{op: OP_MUL_INTERP, cond: COND_NONE,     jump: '0,          last: 1'b0};
         3'd3: w = '{op: OP_DIV_INIT,   cond: COND_NONE,     jump: '0,          last: 1'b0};
         3'd4: w = '{op: OP_DIV_STEP,   cond: COND_DIV_MORE, jump: PC_DIV_STEP, last: 1'b0};
         3'd5: w = '{op: OP_ACC_FORM,   cond: COND_NONE,     jump: '0,          last: 1'b0};
         3'd6: w = '{op: OP_MUL_STEP,   cond: COND_NONE,     jump: '0,          last: 1'b0};
         3'd7: w = '{op: OP_FINISH,     cond: COND_NONE,     jump: '0,          last: 1'b1};
         default: w = '{op: OP_NOP,     cond: COND_NONE,     jump: '0,          last: 1'b1};
      endcase
      return w;
   endfunction

endpackage

### design/speed_slew_rate_limiter_unit.sv
// ----------------------------------------------------------------------------
// speed_slew_rate_limiter_unit
// Moves a held speed toward the target by at most one acceleration or
// deceleration step per transaction, under control of a microcode table.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  req_*    in         time_step, target_speed, measured_speed
//  rsp_*    out        limited_speed
//  csr_*    in         register index, write data
//
//  When the acceleration is interpolated the 32-step divider dominates a
//  transaction; otherwise the divider steps are skipped.
//  One transaction is worked on at a time; req_tready is low while busy.
//  A result waits in the output register; the final step stalls only while
//  that register is still full. csr writes are always taken.
//  Reset is synchronous; it clears the held speed and sets config registers to defaults.
// ----------------------------------------------------------------------------
module speed_slew_rate_limiter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [15:0] time_step, [47:16] target_speed, [79:48] measured_speed
   input  logic [sslr_pkg::REQ_W-1:0]           req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] limited_speed
   output logic [sslr_pkg::SPEED_W-1:0]         rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sslr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sslr_pkg::SPEED_W-1:0]         csr_wdata
);

   sslr_pkg::ctl_type   ctl;
   sslr_pkg::flags_type flags;
   logic                busy;
   logic                start;
   logic                fin;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   assign req_tready = ~busy;
   assign start      = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign fin        = ctl.op == sslr_pkg::OP_FINISH;

   sslr_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_full (rsp_tvalid_ff & ~rsp_tready),
      .flags    (flags),
      .ctl      (ctl),
      .busy     (busy)
   );

   sslr_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_data (req_tdata),
      .csr_we   (csr_valid & csr_ready),
      .csr_idx  (csr_index),
      .csr_data (csr_wdata),
      .flags    (flags),
      .result   (rsp_tdata)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (fin)
         rsp_tvalid_in = 1'b1;
      else if (rsp_tready)
         rsp_tvalid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sequencer not busy after accepted transaction");

   a_finish_only_busy: assert property (@(posedge clock) disable iff (reset)
      fin |-> !req_tready)
      else $error("finish step issued while idle");

   a_finish_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      fin |-> !(rsp_tvalid && !rsp_tready))
      else $error("result overwritten while still pending");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(fin))
      else $error("response raised without finish step");

endmodule

### design/sslr_sequencer.sv
// ----------------------------------------------------------------------------
// sslr_sequencer
// Step counter and microcode fetch; evaluates jump conditions.
// ----------------------------------------------------------------------------
module sslr_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  out_full,
   input  sslr_pkg::flags_type   flags,
   output sslr_pkg::ctl_type     ctl,
   output logic                  busy
);

   logic [sslr_pkg::PC_W-1:0] pc_ff, pc_in;
   logic                      busy_ff, busy_in;
   sslr_pkg::ucode_type       word;
   logic                      hold;
   logic                      taken;

   always_comb begin
      word = sslr_pkg::ucode_rom(pc_ff);
      hold = word.last & out_full;
      case (word.cond)
         sslr_pkg::COND_SKIP:     taken = flags.skip;
         sslr_pkg::COND_DIV_MORE: taken = flags.div_more;
         default:                 taken = 1'b0;
      endcase

      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         pc_in   = '0;
         busy_in = start;
      end else if (!hold) begin
         if (word.last) begin
            pc_in   = '0;
            busy_in = 1'b0;
         end else if (taken) begin
            pc_in = word.jump;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end

      ctl.op   = (busy_ff && !hold) ? word.op : sslr_pkg::OP_NOP;
      ctl.load = start & ~busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

### design/sslr_datapath.sv
// ----------------------------------------------------------------------------
// sslr_datapath
// Config registers, held output, shared multiplier and radix-2 divider.
// ----------------------------------------------------------------------------
module sslr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  sslr_pkg::ctl_type                   ctl,
   input  logic [sslr_pkg::REQ_W-1:0]          req_data,
   input  logic                                csr_we,
   input  logic [sslr_pkg::CSR_IDX_W-1:0]      csr_idx,
   input  logic [sslr_pkg::SPEED_W-1:0]        csr_data,
   output sslr_pkg::flags_type                 flags,
   output logic [sslr_pkg::SPEED_W-1:0]        result
);

   localparam int W = sslr_pkg::SPEED_W;

   logic                     en_ff;
   logic [W-1:0]             hi_ff, lo_ff, thr_ff, dec_ff;
   logic [sslr_pkg::DT_W-1:0] dt_ff;
   logic signed [W-1:0]      tgt_ff, meas_ff, held_ff, held_in;
   logic [W:0]               mag_ff, mag_in;
   logic                     interp_ff, interp_in, accel_ff, accel_in, skip_ff;
   logic                     dneg_ff, dneg_in;
   logic [W-1:0]             dabs_ff, dabs_in;
   logic signed [W:0]        change_ff, change_in;
   logic [2*W-1:0]           prod_ff, prod_in;
   logic [W-1:0]             mul_a, mul_b;
   logic [W-1:0]             rem_ff, rem_in, quo_ff, quo_in;
   logic [W:0]               div_t, div_d;
   logic                     div_ge;
   logic [sslr_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [W-1:0]             acc_ff, acc_in;
   logic [W-1:0]             result_ff, result_in;
   logic [W-1:0]             step;
   logic signed [W+1:0]      step_ext, chg_ext;
   logic                     unlimited, go_up, go_dn;
   logic signed [W-1:0]      limited;

   always_comb begin
      mag_in    = meas_ff[W-1] ? (W+1)'(-$signed({meas_ff[W-1], meas_ff}))
                               : {1'b0, meas_ff};
      interp_in = mag_in < {1'b0, thr_ff};
      if (held_ff[W-1] != tgt_ff[W-1])
         accel_in = 1'b1;
      else if (!held_ff[W-1])
         accel_in = held_ff <= tgt_ff;
      else
         accel_in = held_ff > tgt_ff;
      dneg_in   = hi_ff < lo_ff;
      dabs_in   = dneg_in ? lo_ff - hi_ff : hi_ff - lo_ff;
      change_in = $signed({tgt_ff[W-1], tgt_ff}) - $signed({held_ff[W-1], held_ff});

      case (ctl.op)
         sslr_pkg::OP_MUL_INTERP: begin
            mul_a = dabs_ff;
            mul_b = mag_ff[W-1:0];
         end
         default: begin
            mul_a = {{(W-sslr_pkg::DT_W){1'b0}}, dt_ff};
            mul_b = accel_ff ? acc_ff : dec_ff;
         end
      endcase
      prod_in = mul_a * mul_b;

      div_t  = {rem_ff, quo_ff[W-1]};
      div_d  = {1'b0, thr_ff};
      div_ge = div_t >= div_d;
      rem_in = div_ge ? W'(div_t - div_d) : div_t[W-1:0];
      quo_in = {quo_ff[W-2:0], div_ge};

      acc_in = interp_ff ? (dneg_ff ? lo_ff - quo_ff : lo_ff + quo_ff) : hi_ff;

      step      = prod_ff[sslr_pkg::FRAC_W +: W];
      step_ext  = $signed({2'b00, step});
      chg_ext   = $signed({change_ff[W], change_ff});
      unlimited = !accel_ff && (dec_ff == '1);
      go_up     = chg_ext > step_ext;
      go_dn     = chg_ext < -step_ext;
      if (unlimited)
         limited = tgt_ff;
      else if (go_up)
         limited = held_ff + $signed(step);
      else if (go_dn)
         limited = held_ff - $signed(step);
      else
         limited = tgt_ff;

      held_in   = en_ff ? limited : held_ff;
      result_in = en_ff ? limited : tgt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff   <= 1'b1;
         hi_ff   <= '0;
         lo_ff   <= '0;
         thr_ff  <= '0;
         dec_ff  <= '1;
         held_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_idx)
               sslr_pkg::CSR_ENABLED:     en_ff  <= csr_data[0];
               sslr_pkg::CSR_MAX_ACC: begin
                  hi_ff   <= csr_data;
                  held_ff <= '0;
               end
               sslr_pkg::CSR_MAX_ACC_LOW: lo_ff  <= csr_data;
               sslr_pkg::CSR_LOW_SPD_THR: thr_ff <= csr_data;
               sslr_pkg::CSR_MAX_DEC:     dec_ff <= csr_data;
               default: ;
            endcase
         end
         if (ctl.op == sslr_pkg::OP_FINISH)
            held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         dt_ff   <= req_data[sslr_pkg::DT_W-1:0];
         tgt_ff  <= req_data[sslr_pkg::DT_W +: W];
         meas_ff <= req_data[sslr_pkg::DT_W + W +: W];
      end
      case (ctl.op)
         sslr_pkg::OP_PREP: begin
            mag_ff    <= mag_in;
            interp_ff <= interp_in;
            accel_ff  <= accel_in;
            skip_ff   <= !en_ff || !accel_in || !interp_in;
            dneg_ff   <= dneg_in;
            dabs_ff   <= dabs_in;
            change_ff <= change_in;
         end
         sslr_pkg::OP_MUL_INTERP,
         sslr_pkg::OP_MUL_STEP: prod_ff <= prod_in;
         sslr_pkg::OP_DIV_INIT: begin
            rem_ff <= prod_ff[2*W-1:W];
            quo_ff <= prod_ff[W-1:0];
            cnt_ff <= '0;
         end
         sslr_pkg::OP_DIV_STEP: begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 1'b1;
         end
         sslr_pkg::OP_ACC_FORM: acc_ff <= acc_in;
         sslr_pkg::OP_FINISH:   result_ff <= result_in;
         default: ;
      endcase
   end

   assign flags.skip     = skip_ff;
   assign flags.div_more = cnt_ff != sslr_pkg::DIV_CNT_W'(sslr_pkg::DIV_STEPS - 1);
   assign result         = result_ff;

endmodule
